// File: hw/rtl/fds_pkg.sv
// Shared types and constants of the flash download sequencer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package fds_pkg;

   localparam int PAGE_WORDS = 256;
   localparam int WIP_W      = $clog2(PAGE_WORDS);
   localparam logic [WIP_W-1:0] WIP_LAST   = WIP_W'(PAGE_WORDS - 1);
   localparam logic [31:0]      PAGE_BYTES = 32'(4 * PAGE_WORDS);

   localparam int ID_W       = 11;
   localparam int WORD_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROGRAM_ID  = 3'd0,
      CSR_UNLOCK_ID   = 3'd1,
      CSR_SIZE_ID     = 3'd2,
      CSR_TRANSFER_ID = 3'd3,
      CSR_EXIT_ID     = 3'd4,
      CSR_UNLOCK_KEY  = 3'd5,
      CSR_IMAGE_BASE  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_PROGRAM  = 3'd0,
      KIND_UNLOCK   = 3'd1,
      KIND_SIZE     = 3'd2,
      KIND_TRANSFER = 3'd3,
      KIND_EXIT     = 3'd4,
      KIND_UNKNOWN  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      STAGE_IDLE     = 3'd0,
      STAGE_PROGRAM  = 3'd1,
      STAGE_UNLOCKED = 3'd2,
      STAGE_SIZED    = 3'd3,
      STAGE_DONE     = 3'd4,
      STAGE_EXITED   = 3'd5
   } stage_type;

   typedef enum logic [1:0] {
      REPLY_POS  = 2'd0,
      REPLY_NEG  = 2'd1,
      REPLY_NONE = 2'd2
   } reply_type;

   typedef struct packed {
      logic [ID_W-1:0]   program_id;
      logic [ID_W-1:0]   unlock_id;
      logic [ID_W-1:0]   size_id;
      logic [ID_W-1:0]   transfer_id;
      logic [ID_W-1:0]   exit_id;
      logic [WORD_W-1:0] unlock_key;
      logic [WORD_W-1:0] image_base;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic              key_match;
      logic [WORD_W-1:0] payload;
   } cmd_type;

   typedef struct packed {
      reply_type         reply;
      logic              write_valid;
      logic [WORD_W-1:0] write_address;
      logic [WORD_W-1:0] write_data;
      logic              page_commit;
      logic              launch;
   } rsp_type;

endpackage

// File: hw/rtl/flash_download_sequencer.sv
// Flash download sequencer: classifies requests, queues them and runs the
// program / unlock / size / data / exit sequence. An accepted request goes
// into the queue, then into the result register; throughput is one item per
// cycle while results are not stalled, set by the back end's execute stage
// behind a 4-entry queue. Synchronous active-high reset restores the default
// identifiers, clears the key, base, sequence state, queue and result valid.
`timescale 1ns / 1ps

module flash_download_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fds_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fds_pkg::WORD_W-1:0]    csr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // [31:0] payload_word
   input  logic [10:0]                   req_tuser,  // [10:0] request_id
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [31:0] write_address, [63:32] write_data, [64] page_commit, [65] launch,
   // [71:66] zero
   output logic [71:0]                   rsp_tdata,
   output logic [2:0]                    rsp_tuser   // [1:0] reply, [2] write_valid
);

   fds_pkg::cfg_type cfg;
   fds_pkg::cmd_type push_cmd;
   fds_pkg::cmd_type head_cmd;
   fds_pkg::rsp_type rsp;
   logic             queue_full;
   logic             queue_not_empty;
   logic             push;
   logic             pop;

   fds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fds_front u_front (
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   fds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   fds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (queue_not_empty),
      .cmd       (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {6'b0, rsp.launch, rsp.page_commit, rsp.write_data, rsp.write_address};
   assign rsp_tuser = {rsp.write_valid, rsp.reply};

endmodule

// File: hw/rtl/fds_csr.sv
// Configuration registers of the flash download sequencer.
// Depends on fds_pkg for the register indexes and the cfg_type bundle.
`timescale 1ns / 1ps

module fds_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fds_pkg::WORD_W-1:0]      csr_data,
   output fds_pkg::cfg_type                cfg
);

   fds_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (fds_pkg::csr_index_type'(csr_index))
            fds_pkg::CSR_PROGRAM_ID:  cfg_in.program_id  = csr_data[fds_pkg::ID_W-1:0];
            fds_pkg::CSR_UNLOCK_ID:   cfg_in.unlock_id   = csr_data[fds_pkg::ID_W-1:0];
            fds_pkg::CSR_SIZE_ID:     cfg_in.size_id     = csr_data[fds_pkg::ID_W-1:0];
            fds_pkg::CSR_TRANSFER_ID: cfg_in.transfer_id = csr_data[fds_pkg::ID_W-1:0];
            fds_pkg::CSR_EXIT_ID:     cfg_in.exit_id     = csr_data[fds_pkg::ID_W-1:0];
            fds_pkg::CSR_UNLOCK_KEY:  cfg_in.unlock_key  = csr_data;
            fds_pkg::CSR_IMAGE_BASE:  cfg_in.image_base  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.program_id  <= fds_pkg::ID_W'(1);
         cfg_ff.unlock_id   <= fds_pkg::ID_W'(2);
         cfg_ff.size_id     <= fds_pkg::ID_W'(3);
         cfg_ff.transfer_id <= fds_pkg::ID_W'(4);
         cfg_ff.exit_id     <= fds_pkg::ID_W'(5);
         cfg_ff.unlock_key  <= '0;
         cfg_ff.image_base  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/fds_front.sv
// Front end: accepts requests and classifies them by identifier.
// Depends on fds_pkg; feeds classified commands into fds_queue.
`timescale 1ns / 1ps

module fds_front (
   input  fds_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fds_pkg::WORD_W-1:0]    req_tdata,
   input  logic [fds_pkg::ID_W-1:0]      req_tuser,
   input  logic                          queue_full,
   output logic                          push,
   output fds_pkg::cmd_type              push_cmd
);

   fds_pkg::kind_type kind;

   // The first matching register wins when identifiers are shared.
   always_comb begin
      if (req_tuser == cfg.program_id) begin
         kind = fds_pkg::KIND_PROGRAM;
      end else if (req_tuser == cfg.unlock_id) begin
         kind = fds_pkg::KIND_UNLOCK;
      end else if (req_tuser == cfg.size_id) begin
         kind = fds_pkg::KIND_SIZE;
      end else if (req_tuser == cfg.transfer_id) begin
         kind = fds_pkg::KIND_TRANSFER;
      end else if (req_tuser == cfg.exit_id) begin
         kind = fds_pkg::KIND_EXIT;
      end else begin
         kind = fds_pkg::KIND_UNKNOWN;
      end
   end

   assign req_tready         = ~queue_full;
   assign push               = req_tvalid & ~queue_full;
   assign push_cmd.kind      = kind;
   assign push_cmd.key_match = (req_tdata == cfg.unlock_key);
   assign push_cmd.payload   = req_tdata;

endmodule

// File: hw/rtl/fds_queue.sv
// Short command queue between the front and back ends.
// Depends on fds_pkg for cmd_type and the queue depth.
`timescale 1ns / 1ps

module fds_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fds_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output fds_pkg::cmd_type  head_cmd
);

   localparam int PTR_W = $clog2(fds_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(fds_pkg::QUEUE_DEPTH + 1);

   fds_pkg::cmd_type entry_ff [fds_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(fds_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/fds_back.sv
// Back end: runs the download sequence on queued commands and holds the
// result register. Depends on fds_pkg.
`timescale 1ns / 1ps

module fds_back (
   input  logic                   clock,
   input  logic                   reset,
   input  fds_pkg::cfg_type       cfg,
   input  logic                   cmd_valid,
   input  fds_pkg::cmd_type       cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fds_pkg::rsp_type       rsp
);

   fds_pkg::stage_type           stage_ff, stage_in;
   logic [fds_pkg::WORD_W-1:0]   remaining_ff, remaining_in;
   logic [fds_pkg::WIP_W-1:0]    wip_ff, wip_in;
   logic [fds_pkg::WORD_W-1:0]   page_address_ff, page_address_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   fds_pkg::rsp_type             rsp_ff, rsp_in;
   logic                         exec;
   logic [fds_pkg::WORD_W-1:0]   remaining_dec;
   logic [fds_pkg::WORD_W-1:0]   word_address;

   // A command executes whenever the result register is free or being drained.
   assign exec = cmd_valid & (~rsp_valid_ff | rsp_ready);
   assign pop  = exec;

   assign remaining_dec = (remaining_ff > 32'd4) ? remaining_ff - 32'd4 : '0;
   assign word_address  = page_address_ff
                        + {{(fds_pkg::WORD_W - fds_pkg::WIP_W - 2){1'b0}}, wip_ff, 2'b00};

   // Next stage.
   always_comb begin
      stage_in = stage_ff;
      if (exec) begin
         case (cmd.kind)
            fds_pkg::KIND_PROGRAM: begin
               stage_in = (stage_ff == fds_pkg::STAGE_IDLE) ? fds_pkg::STAGE_PROGRAM
                                                            : fds_pkg::STAGE_IDLE;
            end
            fds_pkg::KIND_UNLOCK: begin
               stage_in = (stage_ff == fds_pkg::STAGE_PROGRAM && cmd.key_match)
                        ? fds_pkg::STAGE_UNLOCKED : fds_pkg::STAGE_IDLE;
            end
            fds_pkg::KIND_SIZE: begin
               if (stage_ff == fds_pkg::STAGE_UNLOCKED) begin
                  stage_in = fds_pkg::STAGE_SIZED;
               end
            end
            fds_pkg::KIND_TRANSFER: begin
               if (stage_ff == fds_pkg::STAGE_SIZED && remaining_dec == '0) begin
                  stage_in = fds_pkg::STAGE_DONE;
               end
            end
            fds_pkg::KIND_EXIT: begin
               if (stage_ff == fds_pkg::STAGE_DONE) begin
                  stage_in = fds_pkg::STAGE_EXITED;
               end
            end
            default: ;
         endcase
      end
   end

   // Result fields and the datapath registers.
   always_comb begin
      remaining_in    = remaining_ff;
      wip_in          = wip_ff;
      page_address_in = page_address_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      if (exec) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.reply = fds_pkg::REPLY_NEG;
         case (cmd.kind)
            fds_pkg::KIND_PROGRAM: begin
               if (stage_ff == fds_pkg::STAGE_IDLE) begin
                  page_address_in = cfg.image_base;
                  wip_in          = '0;
                  remaining_in    = '0;
                  rsp_in.reply    = fds_pkg::REPLY_POS;
               end
            end
            fds_pkg::KIND_UNLOCK: begin
               if (stage_ff == fds_pkg::STAGE_PROGRAM && cmd.key_match) begin
                  rsp_in.reply = fds_pkg::REPLY_POS;
               end
            end
            fds_pkg::KIND_SIZE: begin
               if (stage_ff == fds_pkg::STAGE_UNLOCKED) begin
                  remaining_in = cmd.payload;
                  rsp_in.reply = fds_pkg::REPLY_POS;
               end
            end
            fds_pkg::KIND_TRANSFER: begin
               if (stage_ff == fds_pkg::STAGE_SIZED) begin
                  rsp_in.reply         = fds_pkg::REPLY_POS;
                  rsp_in.write_valid   = 1'b1;
                  rsp_in.write_address = word_address;
                  rsp_in.write_data    = cmd.payload;
                  remaining_in         = remaining_dec;
                  if (wip_ff == fds_pkg::WIP_LAST) begin
                     rsp_in.page_commit = 1'b1;
                     page_address_in    = page_address_ff + fds_pkg::PAGE_BYTES;
                     wip_in             = '0;
                  end else begin
                     wip_in = wip_ff + fds_pkg::WIP_W'(1);
                  end
               end
            end
            fds_pkg::KIND_EXIT: begin
               if (stage_ff == fds_pkg::STAGE_DONE) begin
                  rsp_in.reply  = fds_pkg::REPLY_POS;
                  rsp_in.launch = 1'b1;
               end
            end
            default: begin
               rsp_in.reply = fds_pkg::REPLY_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff        <= fds_pkg::STAGE_IDLE;
         remaining_ff    <= '0;
         wip_ff          <= '0;
         page_address_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stage_ff        <= stage_in;
         remaining_ff    <= remaining_in;
         wip_ff          <= wip_in;
         page_address_ff <= page_address_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_commit_needs_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.page_commit |-> rsp_ff.write_valid)
      else $error("page commit without a flash write");

   a_write_is_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_valid |-> rsp_ff.reply == fds_pkg::REPLY_POS)
      else $error("flash write on a rejected item");

   a_launch_enters_exit: assert property (@(posedge clock) disable iff (reset)
      exec && stage_in == fds_pkg::STAGE_EXITED && stage_ff != fds_pkg::STAGE_EXITED
      |=> rsp_valid_ff && rsp_ff.launch)
      else $error("exit stage entered without launch");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !exec |=> $stable(stage_ff) && $stable(remaining_ff) && $stable(page_address_ff))
      else $error("sequence state moved without an executed item");

endmodule

// File: sim/flash_download_sequencer_tb.sv
// Self-checking testbench for the flash download sequencer.
// Holds its own prediction of the request sequence; needs fds_pkg and the
// flash_download_sequencer RTL.
`timescale 1ns / 1ps

module flash_download_sequencer_tb;

   localparam int IDLE_LIMIT = 2000;

   // Deliberate faults that a generated download may carry.
   localparam int FLAW_NONE       = 0;
   localparam int FLAW_BAD_KEY    = 1;
   localparam int FLAW_NO_KEY     = 2;
   localparam int FLAW_NO_SIZE    = 3;
   localparam int FLAW_EXTRA_DATA = 4;

   typedef struct {
      logic [fds_pkg::ID_W-1:0]   id;
      logic [fds_pkg::WORD_W-1:0] word;
   } download_req_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [fds_pkg::CSR_IDX_W-1:0] csr_index = fds_pkg::CSR_PROGRAM_ID;
   logic [fds_pkg::WORD_W-1:0]    csr_data = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [31:0]                   req_tdata = '0;  // [31:0] payload_word
   logic [10:0]                   req_tuser = '0;  // [10:0] request_id
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // [31:0] write_address, [63:32] write_data, [64] page_commit, [65] launch,
   // [71:66] zero
   logic [71:0]                   rsp_tdata;
   logic [2:0]                    rsp_tuser;       // [1:0] reply, [2] write_valid

   flash_download_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predicted state of the sequencer and its registers.
   fds_pkg::cfg_type           dl_cfg;
   fds_pkg::stage_type         dl_stage;
   logic [31:0]                bytes_left;
   logic [fds_pkg::WIP_W-1:0]  page_slot;
   logic [31:0]                page_base;

   download_req_type           req_backlog[$];
   fds_pkg::rsp_type           awaited_results[$];
   int                         queued_total = 0;
   int                         mismatches = 0;
   int                         results_seen = 0;

   function automatic fds_pkg::rsp_type next_download_result(
         input logic [fds_pkg::ID_W-1:0] id, input logic [fds_pkg::WORD_W-1:0] word);
      fds_pkg::rsp_type r;
      r = '0;
      r.reply = fds_pkg::REPLY_NEG;
      if (id == dl_cfg.program_id) begin
         if (dl_stage == fds_pkg::STAGE_IDLE) begin
            dl_stage   = fds_pkg::STAGE_PROGRAM;
            page_base  = dl_cfg.image_base;
            page_slot  = '0;
            bytes_left = '0;
            r.reply    = fds_pkg::REPLY_POS;
         end else begin
            dl_stage = fds_pkg::STAGE_IDLE;
         end
      end else if (id == dl_cfg.unlock_id) begin
         if (dl_stage == fds_pkg::STAGE_PROGRAM && word == dl_cfg.unlock_key) begin
            dl_stage = fds_pkg::STAGE_UNLOCKED;
            r.reply  = fds_pkg::REPLY_POS;
         end else begin
            dl_stage = fds_pkg::STAGE_IDLE;
         end
      end else if (id == dl_cfg.size_id) begin
         if (dl_stage == fds_pkg::STAGE_UNLOCKED) begin
            bytes_left = word;
            dl_stage   = fds_pkg::STAGE_SIZED;
            r.reply    = fds_pkg::REPLY_POS;
         end
      end else if (id == dl_cfg.transfer_id) begin
         if (dl_stage == fds_pkg::STAGE_SIZED) begin
            r.write_valid   = 1'b1;
            r.write_address = page_base + (32'(page_slot) << 2);
            r.write_data    = word;
            bytes_left = (bytes_left > 32'd4) ? bytes_left - 32'd4 : 32'd0;
            if (bytes_left == 32'd0) begin
               dl_stage = fds_pkg::STAGE_DONE;
            end
            if (page_slot == fds_pkg::WIP_LAST) begin
               r.page_commit = 1'b1;
               page_base     = page_base + fds_pkg::PAGE_BYTES;
               page_slot     = '0;
            end else begin
               page_slot = page_slot + 1'b1;
            end
            r.reply = fds_pkg::REPLY_POS;
         end
      end else if (id == dl_cfg.exit_id) begin
         if (dl_stage == fds_pkg::STAGE_DONE) begin
            dl_stage = fds_pkg::STAGE_EXITED;
            r.launch = 1'b1;
            r.reply  = fds_pkg::REPLY_POS;
         end
      end else begin
         r.reply = fds_pkg::REPLY_NONE;
      end
      return r;
   endfunction

   function automatic void queue_request(input logic [fds_pkg::ID_W-1:0] id,
                                         input logic [fds_pkg::WORD_W-1:0] word);
      download_req_type item;
      item.id   = id;
      item.word = word;
      req_backlog.push_back(item);
      queued_total++;
   endfunction

   // The flaw selects a wrong key, a missing key or size request, or two extra
   // data words after the image.
   function automatic void queue_download(input logic [31:0] size_bytes, input int words,
                                          input int flaw);
      // A failing key request first returns the sequencer to idle from any stage.
      queue_request(dl_cfg.unlock_id, ~dl_cfg.unlock_key);
      queue_request(dl_cfg.program_id, $urandom());
      if (flaw != FLAW_NO_KEY) begin
         queue_request(dl_cfg.unlock_id, (flaw == FLAW_BAD_KEY) ?
                       dl_cfg.unlock_key ^ ($urandom() | 32'h1) : dl_cfg.unlock_key);
      end
      if (flaw != FLAW_NO_SIZE) begin
         queue_request(dl_cfg.size_id, size_bytes);
      end
      repeat (words + ((flaw == FLAW_EXTRA_DATA) ? 2 : 0)) begin
         queue_request(dl_cfg.transfer_id, $urandom());
      end
      queue_request(dl_cfg.exit_id, $urandom());
   endfunction

   function automatic void queue_random_traffic(input int budget);
      int          stop_at;
      int          pick;
      int          size;
      int          n;
      logic [10:0] id;
      stop_at = queued_total + budget;
      while (queued_total < stop_at) begin
         pick = $urandom_range(0, 9);
         size = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 64);
         if (pick < 6) begin
            queue_download(size, (size == 0) ? 1 : (size + 3) / 4, FLAW_NONE);
         end else if (pick == 6) begin
            // Full-range size: the image usually stays open and exit is refused.
            queue_download($urandom(), $urandom_range(1, 6), FLAW_NONE);
         end else if (pick < 9) begin
            n = $urandom_range(1, 5);
            repeat (n) begin
               case ($urandom_range(0, 5))
                  0:       id = dl_cfg.program_id;
                  1:       id = dl_cfg.unlock_id;
                  2:       id = dl_cfg.size_id;
                  3:       id = dl_cfg.transfer_id;
                  4:       id = dl_cfg.exit_id;
                  default: id = $urandom_range(0, 2047);
               endcase
               queue_request(id, $urandom());
            end
         end else begin
            queue_download(size, (size == 0) ? 1 : (size + 3) / 4,
                           $urandom_range(FLAW_BAD_KEY, FLAW_EXTRA_DATA));
         end
      end
   endfunction

   task automatic write_csr(input fds_pkg::csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         fds_pkg::CSR_PROGRAM_ID:  dl_cfg.program_id  = val[fds_pkg::ID_W-1:0];
         fds_pkg::CSR_UNLOCK_ID:   dl_cfg.unlock_id   = val[fds_pkg::ID_W-1:0];
         fds_pkg::CSR_SIZE_ID:     dl_cfg.size_id     = val[fds_pkg::ID_W-1:0];
         fds_pkg::CSR_TRANSFER_ID: dl_cfg.transfer_id = val[fds_pkg::ID_W-1:0];
         fds_pkg::CSR_EXIT_ID:     dl_cfg.exit_id     = val[fds_pkg::ID_W-1:0];
         fds_pkg::CSR_UNLOCK_KEY:  dl_cfg.unlock_key  = val;
         fds_pkg::CSR_IMAGE_BASE:  dl_cfg.image_base  = val;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || awaited_results.size() != 0);
   endtask

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int send_gap = 0;
   int send_burst = 1;

   always @(posedge clock) begin : drive_req
      download_req_type nxt;
      bit               load;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(next_download_result(req_tuser, req_tdata));
         end
         load = 1'b0;
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (req_backlog.size() > 0) begin
               load = 1'b1;
               nxt  = req_backlog.pop_front();
               send_burst--;
               if (send_burst <= 0) begin
                  send_burst = $urandom_range(1, 40);
                  send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_tvalid <= load;
            if (load) begin
               req_tdata <= nxt.word;
               req_tuser <= nxt.id;
            end
         end
      end
   end

   // Result monitor with its own stall pattern and one long hold-off.
   int  rx_mode = 0;
   int  rx_left = 0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin : watch_rsp
      fds_pkg::rsp_type want;
      bit               take;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               $display("%0t: result with none expected, got tuser %h tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("reply", 32'(want.reply), 32'(rsp_tuser[1:0]));
               check_field("write_valid", 32'(want.write_valid), 32'(rsp_tuser[2]));
               check_field("write_address", want.write_address, rsp_tdata[31:0]);
               check_field("write_data", want.write_data, rsp_tdata[63:32]);
               check_field("page_commit", 32'(want.page_commit), 32'(rsp_tdata[64]));
               check_field("launch", 32'(want.launch), 32'(rsp_tdata[65]));
            end
         end
         if (!long_hold_done && results_seen >= 300) begin
            long_hold_done = 1'b1;
            hold_left      = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = $urandom_range(0, 2);
               rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            case (rx_mode)
               0:       take = 1'b1;
               1:       take = $urandom_range(0, 1);
               default: take = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_tready <= take;
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_test
      logic [10:0] shared_id;
      dl_cfg.program_id  = 11'd1;
      dl_cfg.unlock_id   = 11'd2;
      dl_cfg.size_id     = 11'd3;
      dl_cfg.transfer_id = 11'd4;
      dl_cfg.exit_id     = 11'd5;
      dl_cfg.unlock_key  = '0;
      dl_cfg.image_base  = '0;
      dl_stage   = fds_pkg::STAGE_IDLE;
      bytes_left = '0;
      page_slot  = '0;
      page_base  = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset identifiers.
      queue_request(dl_cfg.transfer_id, 32'h0);        // data word while idle
      queue_request(11'd0, 32'hFFFF_FFFF);             // unknown identifiers
      queue_request(11'h7FF, 32'h0);
      queue_request(dl_cfg.program_id, 32'h0);
      queue_request(dl_cfg.program_id, 32'h0);         // repeated program drops to idle
      queue_request(dl_cfg.program_id, $urandom());
      queue_request(dl_cfg.unlock_id, 32'hFFFF_FFFF);  // wrong key
      queue_request(dl_cfg.program_id, 32'h0);
      queue_request(dl_cfg.unlock_id, 32'h0);
      queue_request(dl_cfg.exit_id, 32'h0);            // exit before any data
      queue_request(dl_cfg.size_id, 32'h0);            // zero size: one word ends it
      queue_request(dl_cfg.transfer_id, 32'hFFFF_FFFF);
      queue_request(dl_cfg.transfer_id, 32'h0);
      queue_request(dl_cfg.size_id, 32'h4);
      queue_request(dl_cfg.exit_id, 32'h0);
      queue_request(dl_cfg.exit_id, 32'h0);
      queue_request(dl_cfg.unlock_id, 32'h0);          // key request after exit
      queue_request(dl_cfg.program_id, 32'h0);
      queue_request(dl_cfg.unlock_id, 32'h0);
      queue_request(dl_cfg.size_id, 32'h5);            // remaining count saturates
      queue_request(dl_cfg.transfer_id, $urandom());
      queue_request(dl_cfg.transfer_id, $urandom());
      queue_request(dl_cfg.exit_id, 32'h0);
      queue_request(dl_cfg.program_id, 32'h0);         // program after exit
      queue_random_traffic(100);
      wait_idle();

      // Top identifiers and a base that wraps within the first page.
      write_csr(fds_pkg::CSR_PROGRAM_ID, 32'd2047);
      write_csr(fds_pkg::CSR_UNLOCK_ID, 32'd0);
      write_csr(fds_pkg::CSR_SIZE_ID, 32'd1024);
      write_csr(fds_pkg::CSR_TRANSFER_ID, 32'd21);
      write_csr(fds_pkg::CSR_EXIT_ID, 32'hFFFF_F800 | 32'd1000);
      write_csr(fds_pkg::CSR_UNLOCK_KEY, 32'hFFFF_FFFF);
      write_csr(fds_pkg::CSR_IMAGE_BASE, 32'hFFFF_FE00);
      queue_download(fds_pkg::PAGE_BYTES + 32'd4, fds_pkg::PAGE_WORDS + 1, FLAW_NONE);
      queue_random_traffic(100);
      wait_idle();

      write_csr(fds_pkg::CSR_PROGRAM_ID, $urandom_range(0, 2047));
      write_csr(fds_pkg::CSR_UNLOCK_ID, $urandom_range(0, 2047));
      write_csr(fds_pkg::CSR_SIZE_ID, $urandom_range(0, 2047));
      write_csr(fds_pkg::CSR_TRANSFER_ID, $urandom_range(0, 2047));
      write_csr(fds_pkg::CSR_EXIT_ID, $urandom_range(0, 2047));
      write_csr(fds_pkg::CSR_UNLOCK_KEY, $urandom());
      write_csr(fds_pkg::CSR_IMAGE_BASE, $urandom());
      queue_random_traffic(75);
      queue_download(fds_pkg::PAGE_BYTES, fds_pkg::PAGE_WORDS, FLAW_NONE);
      queue_random_traffic(75);
      wait_idle();

      // Exit shares the program identifier, so program takes precedence.
      shared_id = $urandom_range(0, 2047);
      write_csr(fds_pkg::CSR_PROGRAM_ID, shared_id);
      write_csr(fds_pkg::CSR_EXIT_ID, shared_id);
      write_csr(fds_pkg::CSR_UNLOCK_ID, shared_id ^ 11'h001);
      write_csr(fds_pkg::CSR_SIZE_ID, shared_id ^ 11'h002);
      write_csr(fds_pkg::CSR_TRANSFER_ID, shared_id ^ 11'h004);
      write_csr(fds_pkg::CSR_UNLOCK_KEY, $urandom());
      queue_random_traffic(80);
      wait_idle();

      write_csr(fds_pkg::CSR_PROGRAM_ID, 32'd0);
      write_csr(fds_pkg::CSR_UNLOCK_ID, 32'd1);
      write_csr(fds_pkg::CSR_SIZE_ID, 32'd2);
      write_csr(fds_pkg::CSR_TRANSFER_ID, 32'd3);
      write_csr(fds_pkg::CSR_EXIT_ID, 32'd2047);
      write_csr(fds_pkg::CSR_UNLOCK_KEY, 32'h0);
      write_csr(fds_pkg::CSR_IMAGE_BASE, 32'h0);
      queue_random_traffic(150);
      wait_idle();

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
